// ----- sv/tcm_pkg.sv -----
// ----------------------------------------------------------------------------
// tcm_pkg
// shared types, constants and helpers of the terminal cursor motion unit
// ----------------------------------------------------------------------------
`default_nettype none

package tcm_pkg;

    // tab stop bitmap geometry
    localparam int MAX_COLS     = 256;
    localparam int TAB_INTERVAL = 8;
    localparam int TAB_IDX_W    = $clog2(MAX_COLS);
    localparam int TREE_N       = 1 << TAB_IDX_W;

    // payload widths
    localparam int COL_W   = 8;
    localparam int ROW_W   = 8;
    localparam int CNT_W   = 8;
    localparam int KIND_W  = 4;
    localparam int CFG_W   = 9;
    localparam int CFG_IDX_W = 3;

    // command codes
    typedef enum logic [KIND_W-1:0] {
        CMD_UP        = 4'd0,
        CMD_DOWN      = 4'd1,
        CMD_LEFT      = 4'd2,
        CMD_RIGHT     = 4'd3,
        CMD_ABS       = 4'd4,
        CMD_TAB_NEXT  = 4'd5,
        CMD_TAB_SET   = 4'd6,
        CMD_TAB_CLR   = 4'd7,
        CMD_TAB_CLRALL = 4'd8,
        CMD_TO_LINE   = 4'd9,
        CMD_TO_COL    = 4'd10
    } cmd_kind_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCREEN_COLS   = 3'd0,
        REG_SCREEN_ROWS   = 3'd1,
        REG_TOP_MARGIN    = 3'd2,
        REG_BOTTOM_MARGIN = 3'd3,
        REG_ORIGIN_MODE   = 3'd4
    } cfg_idx_t;

    // limits derived from the configuration registers
    typedef struct packed {
        logic [COL_W-1:0] last_col;  // effective width - 1
        logic [ROW_W-1:0] top;       // active top row
        logic [ROW_W-1:0] bot;       // active bottom row
        logic [ROW_W-1:0] row_ofs;   // row offset of absolute moves
    } lim_t;

    // one stop every TAB_INTERVAL columns
    function automatic logic [MAX_COLS-1:0] tab_reset_pattern();
        logic [MAX_COLS-1:0] v;
        v = '0;
        for (int i = 0; i < MAX_COLS; i++)
        begin
            v[i] = ((i % TAB_INTERVAL) == 0);
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- sv/tcm_cfg.sv -----
// ----------------------------------------------------------------------------
// tcm_cfg
// configuration registers and the screen limits derived from them
// ----------------------------------------------------------------------------
`default_nettype none

module tcm_cfg
    import tcm_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 wr_en,
    input  wire logic [CFG_IDX_W-1:0] wr_index,
    input  wire logic [CFG_W-1:0]     wr_data,
    output lim_t                      lim
);

    logic [8:0]       screen_cols_reg;
    logic [8:0]       screen_rows_reg;
    logic [ROW_W-1:0] top_margin_reg;
    logic [ROW_W-1:0] bottom_margin_reg;
    logic             origin_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_cols_reg   <= 9'd80;
            screen_rows_reg   <= 9'd24;
            top_margin_reg    <= 8'd0;
            bottom_margin_reg <= 8'd23;
            origin_mode_reg   <= 1'b0;
        end
        else if (wr_en)
        begin
            case (cfg_idx_t'(wr_index))
                REG_SCREEN_COLS:   screen_cols_reg   <= wr_data;
                REG_SCREEN_ROWS:   screen_rows_reg   <= wr_data;
                REG_TOP_MARGIN:    top_margin_reg    <= wr_data[ROW_W-1:0];
                REG_BOTTOM_MARGIN: bottom_margin_reg <= wr_data[ROW_W-1:0];
                REG_ORIGIN_MODE:   origin_mode_reg   <= wr_data[0];
                default:           ;
            endcase
        end
    end

    logic [COL_W-1:0] col_max;
    logic [ROW_W-1:0] row_max;
    logic [ROW_W-1:0] org_bot;
    logic [ROW_W-1:0] org_top;

    always_comb
    begin
        // width and height limited to 1..256, then minus one
        if (screen_cols_reg == 9'd0)
            col_max = '0;
        else if (screen_cols_reg[8])
            col_max = '1;
        else
            col_max = COL_W'(screen_cols_reg - 9'd1);
        if (32'(col_max) > MAX_COLS - 1)
            col_max = COL_W'(MAX_COLS - 1);

        if (screen_rows_reg == 9'd0)
            row_max = '0;
        else if (screen_rows_reg[8])
            row_max = '1;
        else
            row_max = ROW_W'(screen_rows_reg - 9'd1);

        org_bot = (bottom_margin_reg > row_max) ? row_max : bottom_margin_reg;
        org_top = (top_margin_reg > org_bot) ? org_bot : top_margin_reg;

        lim.last_col = col_max;
        if (origin_mode_reg)
        begin
            lim.top     = org_top;
            lim.bot     = org_bot;
            lim.row_ofs = top_margin_reg;
        end
        else
        begin
            lim.top     = '0;
            lim.bot     = row_max;
            lim.row_ofs = '0;
        end
    end

endmodule

`default_nettype wire

// ----- sv/tcm_tab.sv -----
// ----------------------------------------------------------------------------
// tcm_tab
// tab stop bitmap with next-stop search tree
// ----------------------------------------------------------------------------
`default_nettype none

module tcm_tab
    import tcm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              upd_en,
    input  wire cmd_kind_t         kind,
    input  wire logic [COL_W-1:0]  cur_col,
    input  wire logic [COL_W-1:0]  last_col,
    output logic      [COL_W-1:0]  tab_dest
);

    logic [MAX_COLS-1:0]  stops_reg;
    logic [MAX_COLS-1:0]  stops_next;
    logic [TAB_IDX_W-1:0] cur_idx;

    // search tree: hit flag and lowest hit position per node
    logic [TREE_N-1:0]    hit_l [0:TAB_IDX_W];
    logic [TAB_IDX_W-1:0] pos_l [0:TAB_IDX_W][0:TREE_N-1];

    assign cur_idx = TAB_IDX_W'(cur_col);

    always_comb
    begin
        for (int l = 0; l <= TAB_IDX_W; l++)
        begin
            hit_l[l] = '0;
            for (int n = 0; n < TREE_N; n++)
            begin
                pos_l[l][n] = '0;
            end
        end

        // leaves: set stops right of the cursor and inside the screen
        for (int i = 0; i < MAX_COLS; i++)
        begin
            hit_l[0][i] = stops_reg[i] && (i > int'(cur_col)) && (i <= int'(last_col));
            pos_l[0][i] = TAB_IDX_W'(i);
        end

        for (int l = 1; l <= TAB_IDX_W; l++)
        begin
            for (int n = 0; n < (TREE_N >> l); n++)
            begin
                hit_l[l][n] = hit_l[l-1][2*n] | hit_l[l-1][2*n+1];
                pos_l[l][n] = hit_l[l-1][2*n] ? pos_l[l-1][2*n] : pos_l[l-1][2*n+1];
            end
        end

        tab_dest = hit_l[TAB_IDX_W][0] ? COL_W'(pos_l[TAB_IDX_W][0]) : last_col;
    end

    always_comb
    begin
        stops_next = stops_reg;
        case (kind)
            CMD_TAB_SET:
            begin
                if (int'(cur_col) < MAX_COLS)
                    stops_next[cur_idx] = 1'b1;
            end
            CMD_TAB_CLR:
            begin
                if (int'(cur_col) < MAX_COLS)
                    stops_next[cur_idx] = 1'b0;
            end
            CMD_TAB_CLRALL: stops_next = '0;
            default:        ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stops_reg <= tab_reset_pattern();
        else if (upd_en)
            stops_reg <= stops_next;
    end

endmodule

`default_nettype wire

// ----- sv/tcm_move.sv -----
// ----------------------------------------------------------------------------
// tcm_move
// new cursor position for one command, with clamping to the active area
// ----------------------------------------------------------------------------
`default_nettype none

module tcm_move
    import tcm_pkg::*;
(
    input  wire cmd_kind_t         kind,
    input  wire logic [CNT_W-1:0]  count,
    input  wire logic [COL_W-1:0]  target_col,
    input  wire logic [ROW_W-1:0]  target_row,
    input  wire logic [COL_W-1:0]  cur_col,
    input  wire logic [ROW_W-1:0]  cur_row,
    input  wire logic [COL_W-1:0]  tab_dest,
    input  wire lim_t              lim,
    output logic      [COL_W-1:0]  new_col,
    output logic      [ROW_W-1:0]  new_row
);

    logic [ROW_W:0]   row_sum;
    logic [COL_W:0]   col_sum;
    logic [ROW_W:0]   abs_row;
    logic [ROW_W-1:0] abs_row_clamped;
    logic [COL_W-1:0] abs_col_clamped;

    always_comb
    begin
        row_sum = {1'b0, cur_row} + (ROW_W+1)'(count);
        col_sum = {1'b0, cur_col} + (COL_W+1)'(count);
        abs_row = {1'b0, target_row} + {1'b0, lim.row_ofs};

        if (abs_row < {1'b0, lim.top})
            abs_row_clamped = lim.top;
        else if (abs_row > {1'b0, lim.bot})
            abs_row_clamped = lim.bot;
        else
            abs_row_clamped = abs_row[ROW_W-1:0];

        abs_col_clamped = (target_col > lim.last_col) ? lim.last_col : target_col;

        new_col = cur_col;
        new_row = cur_row;
        case (kind)
            CMD_UP:
            begin
                if (count != '0)
                begin
                    // above or at top always lands on top
                    if (cur_row > lim.top && count < (cur_row - lim.top))
                        new_row = cur_row - count;
                    else
                        new_row = lim.top;
                end
            end
            CMD_DOWN:
            begin
                if (count != '0 && cur_row != lim.bot)
                begin
                    if (row_sum <= {1'b0, lim.bot})
                        new_row = row_sum[ROW_W-1:0];
                    else
                        new_row = lim.bot;
                end
            end
            CMD_LEFT:
            begin
                if (count != '0 && cur_col != '0)
                    new_col = (count < cur_col) ? (cur_col - count) : '0;
            end
            CMD_RIGHT:
            begin
                if (count != '0 && cur_col != lim.last_col)
                begin
                    if (col_sum <= {1'b0, lim.last_col})
                        new_col = col_sum[COL_W-1:0];
                    else
                        new_col = lim.last_col;
                end
            end
            CMD_ABS:
            begin
                new_col = abs_col_clamped;
                new_row = abs_row_clamped;
            end
            CMD_TAB_NEXT: new_col = tab_dest;
            CMD_TO_LINE:  new_row = abs_row_clamped;
            CMD_TO_COL:   new_col = abs_col_clamped;
            default:      ;
        endcase
    end

endmodule

`default_nettype wire

// ----- sv/terminal_cursor_motion_with_tabs_unit.sv -----
// ----------------------------------------------------------------------------
// terminal_cursor_motion_with_tabs_unit
// text terminal cursor unit: relative, absolute and tab moves plus tab stops
// ----------------------------------------------------------------------------
//
//  channel  | handshake               | payload
//  ---------+-------------------------+------------------------------------
//  in       | in_valid / in_stall     | kind, count, target_col, target_row
//  out      | out_valid / out_stall   | col, row, changed
//  cfg      | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
//  one command per cycle sustained while out_stall is low; an input beat
//  passes the command register, then the result register, to its result beat
//  cursor and tab bitmap update in the same cycle the result is formed, so
//  back-to-back commands see each other's effect
//  reset: cursor at 0,0, tab stops every eighth column, registers at defaults
//  out_stall holds the result register; the command register then fills and
//  in_stall rises only once both are occupied
//
`default_nettype none

module terminal_cursor_motion_with_tabs_unit
    import tcm_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [KIND_W-1:0]    kind,
    input  wire logic [CNT_W-1:0]     count,
    input  wire logic [COL_W-1:0]     target_col,
    input  wire logic [ROW_W-1:0]     target_row,

    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic      [COL_W-1:0]     col,
    output logic      [ROW_W-1:0]     row,
    output logic                      changed,

    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    // command register
    logic             cmd_vld_reg;
    cmd_kind_t        kind_reg;
    logic [CNT_W-1:0] count_reg;
    logic [COL_W-1:0] tcol_reg;
    logic [ROW_W-1:0] trow_reg;

    // cursor state
    logic [COL_W-1:0] cur_col_reg;
    logic [ROW_W-1:0] cur_row_reg;

    // result register
    logic             out_vld_reg;
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic             changed_reg;

    lim_t             lim;
    logic [COL_W-1:0] tab_dest;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_next;
    logic             advance;
    logic             in_beat;

    // config writes are always taken
    assign cfg_ready = 1'b1;

    // command moves on when the result register is empty or being drained
    assign advance  = cmd_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = cmd_vld_reg && !advance;
    assign in_beat  = in_valid && !in_stall;

    tcm_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .lim      (lim)
    );

    tcm_tab u_tab (
        .clk      (clk),
        .rst_n    (rst_n),
        .upd_en   (advance),
        .kind     (kind_reg),
        .cur_col  (cur_col_reg),
        .last_col (lim.last_col),
        .tab_dest (tab_dest)
    );

    tcm_move u_move (
        .kind       (kind_reg),
        .count      (count_reg),
        .target_col (tcol_reg),
        .target_row (trow_reg),
        .cur_col    (cur_col_reg),
        .cur_row    (cur_row_reg),
        .tab_dest   (tab_dest),
        .lim        (lim),
        .new_col    (col_next),
        .new_row    (row_next)
    );

    // control and cursor state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
            cur_col_reg <= '0;
            cur_row_reg <= '0;
        end
        else
        begin
            if (in_beat)
                cmd_vld_reg <= 1'b1;
            else if (advance)
                cmd_vld_reg <= 1'b0;

            if (advance)
            begin
                out_vld_reg <= 1'b1;
                cur_col_reg <= col_next;
                cur_row_reg <= row_next;
            end
            else if (!out_stall)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            kind_reg  <= cmd_kind_t'(kind);
            count_reg <= count;
            tcol_reg  <= target_col;
            trow_reg  <= target_row;
        end
        if (advance)
        begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            changed_reg <= (col_next != cur_col_reg) || (row_next != cur_row_reg);
        end
    end

    assign out_valid = out_vld_reg;
    assign col       = col_reg;
    assign row       = row_reg;
    assign changed   = changed_reg;

    // result register mirrors the cursor right after an update
    a_result_is_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid && col == cur_col_reg && row == cur_row_reg)
        else $error("result beat does not match cursor state");

    // changed flag agrees with the cursor movement
    a_changed_flag: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> changed == ((cur_col_reg != $past(cur_col_reg))
                                || (cur_row_reg != $past(cur_row_reg))))
        else $error("changed flag disagrees with cursor movement");

    // tab maintenance never moves the cursor
    a_tab_cmd_still: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (kind_reg == CMD_TAB_SET || kind_reg == CMD_TAB_CLR
                    || kind_reg == CMD_TAB_CLRALL) |=> !changed)
        else $error("tab maintenance command moved the cursor");

    // an empty command register never holds off the input
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd_vld_reg |-> !in_stall)
        else $error("input stalled with empty command register");

endmodule

`default_nettype wire
